### hdl/slt_pkg.sv
package slt_pkg;

    typedef enum logic [3:0] {
        KIND_PLUS    = 4'd0,
        KIND_MINUS   = 4'd1,
        KIND_STAR    = 4'd2,
        KIND_SLASH   = 4'd3,
        KIND_ASSIGN  = 4'd4,
        KIND_UNKNOWN = 4'd5,
        KIND_IDENT   = 4'd6,
        KIND_LET     = 4'd7,
        KIND_PRINT   = 4'd8,
        KIND_NUMBER  = 4'd9,
        KIND_END     = 4'd10,
        KIND_CHAR    = 4'd11
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_WORD = 2'd1,
        MODE_NUM  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DECODE = 2'd1,
        ST_CHARS  = 2'd2,
        ST_FRESH  = 2'd3
    } state_t;

    typedef struct packed {
        kind_t        kind;
        logic [15:0]  line;
        logic [15:0]  column;
        logic [30:0]  number;
        logic [5:0]   length;
        logic [7:0]   chr;
        logic         truncated;
        logic         last;
    } result_t;

    localparam logic [7:0]  CH_END     = 8'h00;
    localparam logic [7:0]  CH_NL      = 8'h0A;
    localparam logic [7:0]  CH_SPACE   = 8'h20;
    localparam logic [7:0]  CH_PLUS    = 8'h2B;
    localparam logic [7:0]  CH_MINUS   = 8'h2D;
    localparam logic [7:0]  CH_STAR    = 8'h2A;
    localparam logic [7:0]  CH_SLASH   = 8'h2F;
    localparam logic [7:0]  CH_ASSIGN  = 8'h3D;
    localparam logic [7:0]  CH_ZERO    = 8'h30;
    localparam logic [7:0]  CH_NINE    = 8'h39;
    localparam logic [7:0]  CH_UNDER   = 8'h5F;
    localparam logic [23:0] LET_WORD   = "let";
    localparam logic [39:0] PRINT_WORD = "print";
    localparam int          LET_LEN    = 3;
    localparam int          PRINT_LEN  = 5;
    localparam logic [30:0] NUM_MAX    = 31'h7FFF_FFFF;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || c == CH_UNDER;
    endfunction

    function automatic logic [7:0] let_char(input logic [1:0] i);
        logic [7:0] ch;
        unique case (i)
            2'd0:    ch = LET_WORD[23:16];
            2'd1:    ch = LET_WORD[15:8];
            2'd2:    ch = LET_WORD[7:0];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] print_char(input logic [2:0] i);
        logic [7:0] ch;
        unique case (i)
            3'd0:    ch = PRINT_WORD[39:32];
            3'd1:    ch = PRINT_WORD[31:24];
            3'd2:    ch = PRINT_WORD[23:16];
            3'd3:    ch = PRINT_WORD[15:8];
            3'd4:    ch = PRINT_WORD[7:0];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### hdl/simple_language_tokenizer_core.sv
// Streaming tokenizer for a small language, one text byte per input beat.
// Input channel: char_valid / char_ready with char_code; byte 0 ends the text.
// Output channel: token_valid / token_ready, one token per beat;
// last_result marks the final beat caused by an input byte.
// Each byte is first captured, then decoded against the scan mode; its first
// token then goes into the output register.
// A byte that closes a number or keyword adds a further step, in which the byte
// itself is handled; a byte that closes an identifier first streams each stored
// name character out of the name memory, then handles the byte itself.
// Identifier characters are read from a single-port-read memory with a
// registered read port; the read for the next character is issued as the current
// one is sent. Writes happen only while a word is open and reads only while
// it is being closed, so the two never touch the same entry at once.
// A new byte is taken only when the previous one is fully handled; a finished
// token waits in an output register, so a stall on token_ready holds the
// pending beat and stops decoding until the register frees up.
// Reset clears the scanner: line 1, column 0, no open token, output empty.
module simple_language_tokenizer_core
    import slt_pkg::*;
#(
    parameter int MAX_NAME_LEN = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_ready,
    input  logic [7:0]  char_code,
    output logic        token_valid,
    input  logic        token_ready,
    output logic [3:0]  token_kind,
    output logic [15:0] token_line,
    output logic [15:0] token_column,
    output logic [30:0] number_value,
    output logic [5:0]  name_length,
    output logic [7:0]  name_char,
    output logic        name_truncated,
    output logic        last_result
);

    localparam int ADDR_W = $clog2(MAX_NAME_LEN);
    localparam int CNT_W  = $clog2(MAX_NAME_LEN + 1);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_NAME_LEN);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_LET   = CNT_W'(LET_LEN);
    localparam logic [CNT_W-1:0] CNT_PRINT = CNT_W'(PRINT_LEN);

    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    logic [7:0]        byte_reg, byte_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              ovf_reg, ovf_next;
    logic              kwl_reg, kwl_next;
    logic              kwp_reg, kwp_next;
    logic [30:0]       acc_reg, acc_next;
    logic [15:0]       sline_reg, sline_next;
    logic [15:0]       scol_reg, scol_next;
    logic [15:0]       line_reg, line_next;
    logic [15:0]       col_reg, col_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    logic              emit;
    result_t           res;
    logic              can_emit;
    result_t           out_data;

    logic              is_cont;
    logic              is_num;
    logic              fresh_emits;
    logic              word_let;
    logic              word_print;
    logic              do_fresh;
    logic              fresh_go;
    logic              last_char;
    logic [34:0]       acc_prod;

    assign is_cont     = is_word_char(byte_reg);
    assign is_num      = is_digit(byte_reg);
    assign fresh_emits = !(is_letter(byte_reg) || is_num || byte_reg == CH_NL
                           || byte_reg == CH_SPACE);
    assign word_let    = !ovf_reg && count_reg == CNT_LET && kwl_reg;
    assign word_print  = !ovf_reg && count_reg == CNT_PRINT && kwp_reg;
    assign do_fresh    = (state_reg == ST_DECODE && mode_reg == MODE_IDLE)
                         || state_reg == ST_FRESH;
    assign fresh_go    = do_fresh && (!fresh_emits || can_emit);
    assign last_char   = idx_reg == (count_reg - CNT_ONE);
    assign acc_prod    = 35'({acc_reg, 3'b000}) + 35'({acc_reg, 1'b0})
                         + 35'(byte_reg - CH_ZERO);
    assign char_ready  = state_reg == ST_IDLE;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (char_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (mode_reg)
                    MODE_WORD:
                    begin
                        if (is_cont)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (can_emit)
                        begin
                            state_next = (word_let || word_print) ? ST_FRESH : ST_CHARS;
                        end
                    end
                    MODE_NUM:
                    begin
                        if (is_num)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (can_emit)
                        begin
                            state_next = ST_FRESH;
                        end
                    end
                    default:
                    begin
                        if (fresh_go)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_CHARS:
            begin
                if (can_emit && last_char)
                begin
                    state_next = ST_FRESH;
                end
            end
            ST_FRESH:
            begin
                if (fresh_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mode_next  = mode_reg;
        byte_next  = byte_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        ovf_next   = ovf_reg;
        kwl_next   = kwl_reg;
        kwp_next   = kwp_reg;
        acc_next   = acc_reg;
        sline_next = sline_reg;
        scol_next  = scol_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        wr_en      = 1'b0;
        wr_addr    = count_reg[ADDR_W-1:0];
        rd_en      = 1'b0;
        rd_addr    = ADDR_W'(idx_reg + CNT_ONE);
        emit       = 1'b0;
        res        = '0;

        if (state_reg == ST_IDLE && char_valid)
        begin
            byte_next = char_code;
            col_next  = col_reg + 16'd1;
        end

        if (state_reg == ST_DECODE && mode_reg == MODE_WORD)
        begin
            if (is_cont)
            begin
                if (count_reg < CNT_MAX)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_ONE;
                    if (count_reg < CNT_LET)
                    begin
                        kwl_next = kwl_reg && byte_reg == let_char(count_reg[1:0]);
                    end
                    if (count_reg < CNT_PRINT)
                    begin
                        kwp_next = kwp_reg && byte_reg == print_char(count_reg[2:0]);
                    end
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            else if (can_emit)
            begin
                emit       = 1'b1;
                mode_next  = MODE_IDLE;
                res.line   = sline_reg;
                res.column = scol_reg;
                if (word_let)
                begin
                    res.kind = KIND_LET;
                    res.last = !fresh_emits;
                end
                else if (word_print)
                begin
                    res.kind = KIND_PRINT;
                    res.last = !fresh_emits;
                end
                else
                begin
                    res.kind      = KIND_IDENT;
                    res.length    = 6'(count_reg);
                    res.truncated = ovf_reg;
                    rd_en         = 1'b1;
                    rd_addr       = '0;
                    idx_next      = '0;
                end
            end
        end

        if (state_reg == ST_DECODE && mode_reg == MODE_NUM)
        begin
            if (is_num)
            begin
                acc_next = (acc_prod > 35'(NUM_MAX)) ? NUM_MAX : acc_prod[30:0];
            end
            else if (can_emit)
            begin
                emit       = 1'b1;
                mode_next  = MODE_IDLE;
                res.kind   = KIND_NUMBER;
                res.line   = sline_reg;
                res.column = scol_reg;
                res.number = acc_reg;
                res.last   = !fresh_emits;
            end
        end

        if (state_reg == ST_CHARS && can_emit)
        begin
            emit     = 1'b1;
            res.kind = KIND_CHAR;
            res.chr  = rd_data;
            res.last = last_char && !fresh_emits;
            idx_next = idx_reg + CNT_ONE;
            rd_en    = !last_char;
        end

        if (fresh_go)
        begin
            mode_next  = MODE_IDLE;
            res.line   = line_reg;
            res.column = col_reg;
            res.last   = 1'b1;
            emit       = fresh_emits;
            if (byte_reg == CH_END)
            begin
                res.kind  = KIND_END;
                line_next = 16'd1;
                col_next  = 16'd0;
            end
            else if (is_letter(byte_reg))
            begin
                mode_next  = MODE_WORD;
                sline_next = line_reg;
                scol_next  = col_reg;
                count_next = CNT_ONE;
                ovf_next   = 1'b0;
                kwl_next   = byte_reg == let_char(2'd0);
                kwp_next   = byte_reg == print_char(3'd0);
                wr_en      = 1'b1;
                wr_addr    = '0;
            end
            else if (is_num)
            begin
                mode_next  = MODE_NUM;
                sline_next = line_reg;
                scol_next  = col_reg;
                acc_next   = 31'(byte_reg - CH_ZERO);
            end
            else if (byte_reg == CH_NL)
            begin
                line_next = line_reg + 16'd1;
                col_next  = 16'd0;
            end
            else
            begin
                priority case (byte_reg)
                    CH_PLUS:   res.kind = KIND_PLUS;
                    CH_MINUS:  res.kind = KIND_MINUS;
                    CH_STAR:   res.kind = KIND_STAR;
                    CH_SLASH:  res.kind = KIND_SLASH;
                    CH_ASSIGN: res.kind = KIND_ASSIGN;
                    default:
                    begin
                        res.kind   = KIND_UNKNOWN;
                        res.line   = '0;
                        res.column = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            ovf_reg   <= 1'b0;
            kwl_reg   <= 1'b0;
            kwp_reg   <= 1'b0;
            acc_reg   <= '0;
            sline_reg <= '0;
            scol_reg  <= '0;
            line_reg  <= 16'd1;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            ovf_reg   <= ovf_next;
            kwl_reg   <= kwl_next;
            kwp_reg   <= kwp_next;
            acc_reg   <= acc_next;
            sline_reg <= sline_next;
            scol_reg  <= scol_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    slt_name_store #(
        .MAX_NAME_LEN (MAX_NAME_LEN),
        .ADDR_W       (ADDR_W)
    ) u_name_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (byte_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    slt_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .load_data (res),
        .can_load  (can_emit),
        .valid     (token_valid),
        .ready     (token_ready),
        .data      (out_data)
    );

    assign token_kind     = out_data.kind;
    assign token_line     = out_data.line;
    assign token_column   = out_data.column;
    assign number_value   = out_data.number;
    assign name_length    = out_data.length;
    assign name_char      = out_data.chr;
    assign name_truncated = out_data.truncated;
    assign last_result    = out_data.last;

endmodule

### hdl/slt_name_store.sv
module slt_name_store
    import slt_pkg::*;
#(
    parameter int MAX_NAME_LEN = 32,
    parameter int ADDR_W       = 5
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] name_mem [MAX_NAME_LEN];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            name_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= name_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/slt_out_stage.sv
module slt_out_stage
    import slt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    output logic    can_load,
    output logic    valid,
    input  logic    ready,
    output result_t data
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign can_load = !valid_reg || ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

### sim/token_checker.sv
`timescale 1ns / 1ps

module token_checker
    import slt_pkg::*;
#(
    parameter int NAME_LEN = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    input  logic        char_ready,
    input  logic [7:0]  char_code,
    input  logic        token_valid,
    input  logic        token_ready,
    input  logic [3:0]  token_kind,
    input  logic [15:0] token_line,
    input  logic [15:0] token_column,
    input  logic [30:0] number_value,
    input  logic [5:0]  name_length,
    input  logic [7:0]  name_char,
    input  logic        name_truncated,
    input  logic        last_result,
    output int          failures,
    output int          pending,
    output int          tokens_checked
);

    result_t     expected_tokens[$];
    result_t     want;
    mode_t       scan_mode;
    logic [7:0]  name_buffer[NAME_LEN];
    logic [5:0]  name_count;
    logic        name_overflow;
    logic [30:0] number_acc;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] line_count;
    logic [15:0] column_count;
    int          batch_size;

    function automatic logic alpha_byte(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic logic decimal_byte(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    task automatic report_mismatch(input string what);
        failures++;
        if (failures <= 40)
            $display("%0t: token %0d: %s", $time, tokens_checked, what);
    endtask

    task automatic push_expected(input kind_t kind, input logic [15:0] ln,
                                 input logic [15:0] col, input logic [30:0] num,
                                 input logic [5:0] len, input logic [7:0] chr,
                                 input logic trunc);
        result_t r;
        r.kind      = kind;
        r.line      = ln;
        r.column    = col;
        r.number    = num;
        r.length    = len;
        r.chr       = chr;
        r.truncated = trunc;
        r.last      = 1'b0;
        expected_tokens.push_back(r);
        batch_size++;
    endtask

    task automatic store_name_char(input logic [7:0] c);
        if (name_count < NAME_LEN) begin
            name_buffer[name_count] = c;
            name_count = name_count + 6'd1;
        end
        else
            name_overflow = 1'b1;
    endtask

    task automatic tokenize_byte(input logic [7:0] c);
        logic [63:0] widened;
        result_t     tail;
        int          i;
        batch_size = 0;
        column_count = column_count + 16'd1;

        if (scan_mode == MODE_WORD) begin
            if (alpha_byte(c) || decimal_byte(c) || c == CH_UNDER) begin
                store_name_char(c);
                return;
            end
            if (!name_overflow && name_count == LET_LEN &&
                {name_buffer[0], name_buffer[1], name_buffer[2]} == LET_WORD)
                push_expected(KIND_LET, start_line, start_column, '0, '0, '0, 1'b0);
            else if (!name_overflow && name_count == PRINT_LEN &&
                     {name_buffer[0], name_buffer[1], name_buffer[2],
                      name_buffer[3], name_buffer[4]} == PRINT_WORD)
                push_expected(KIND_PRINT, start_line, start_column, '0, '0, '0, 1'b0);
            else begin
                push_expected(KIND_IDENT, start_line, start_column, '0, name_count, '0,
                              name_overflow);
                for (i = 0; i < name_count; i++)
                    push_expected(KIND_CHAR, '0, '0, '0, '0, name_buffer[i], 1'b0);
            end
        end
        else if (scan_mode == MODE_NUM) begin
            if (decimal_byte(c)) begin
                widened = number_acc;
                widened = widened * 10 + (c - CH_ZERO);
                number_acc = (widened > NUM_MAX) ? NUM_MAX : widened[30:0];
                return;
            end
            push_expected(KIND_NUMBER, start_line, start_column, number_acc, '0, '0, 1'b0);
        end
        scan_mode = MODE_IDLE;

        if (c == CH_END) begin
            push_expected(KIND_END, line_count, column_count, '0, '0, '0, 1'b0);
            line_count = 16'd1;
            column_count = 16'd0;
        end
        else if (alpha_byte(c)) begin
            scan_mode = MODE_WORD;
            start_line = line_count;
            start_column = column_count;
            name_count = '0;
            name_overflow = 1'b0;
            store_name_char(c);
        end
        else if (decimal_byte(c)) begin
            scan_mode = MODE_NUM;
            start_line = line_count;
            start_column = column_count;
            number_acc = 31'(c - CH_ZERO);
        end
        else if (c == CH_PLUS)
            push_expected(KIND_PLUS, line_count, column_count, '0, '0, '0, 1'b0);
        else if (c == CH_MINUS)
            push_expected(KIND_MINUS, line_count, column_count, '0, '0, '0, 1'b0);
        else if (c == CH_STAR)
            push_expected(KIND_STAR, line_count, column_count, '0, '0, '0, 1'b0);
        else if (c == CH_SLASH)
            push_expected(KIND_SLASH, line_count, column_count, '0, '0, '0, 1'b0);
        else if (c == CH_ASSIGN)
            push_expected(KIND_ASSIGN, line_count, column_count, '0, '0, '0, 1'b0);
        else if (c == CH_NL) begin
            line_count = line_count + 16'd1;
            column_count = 16'd0;
        end
        else if (c != CH_SPACE)
            push_expected(KIND_UNKNOWN, '0, '0, '0, '0, '0, 1'b0);

        if (batch_size > 0) begin
            tail = expected_tokens.pop_back();
            tail.last = 1'b1;
            expected_tokens.push_back(tail);
        end
    endtask

    task automatic check_token();
        tokens_checked++;
        if (expected_tokens.size() == 0) begin
            report_mismatch($sformatf("unexpected token, kind %0d", token_kind));
            return;
        end
        want = expected_tokens.pop_front();
        if (token_kind != want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", token_kind, want.kind));
        if (token_line != want.line)
            report_mismatch($sformatf("line %0d, expected %0d", token_line, want.line));
        if (token_column != want.column)
            report_mismatch($sformatf("column %0d, expected %0d", token_column,
                                      want.column));
        if (number_value != want.number)
            report_mismatch($sformatf("number %0d, expected %0d", number_value,
                                      want.number));
        if (name_length != want.length)
            report_mismatch($sformatf("length %0d, expected %0d", name_length,
                                      want.length));
        if (name_char != want.chr)
            report_mismatch($sformatf("char %0d, expected %0d", name_char, want.chr));
        if (name_truncated != want.truncated)
            report_mismatch($sformatf("truncated %0d, expected %0d", name_truncated,
                                      want.truncated));
        if (last_result != want.last)
            report_mismatch($sformatf("last %0d, expected %0d", last_result, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_tokens.delete();
            scan_mode      = MODE_IDLE;
            name_count     = '0;
            name_overflow  = 1'b0;
            number_acc     = '0;
            start_line     = '0;
            start_column   = '0;
            line_count     = 16'd1;
            column_count   = 16'd0;
            failures       = 0;
            pending        = 0;
            tokens_checked = 0;
        end
        else
        begin
            if (token_valid && token_ready)
                check_token();
            if (char_valid && char_ready)
                tokenize_byte(char_code);
            pending = expected_tokens.size();
        end
    end

endmodule

### sim/simple_language_tokenizer_core_test.sv
`timescale 1ns / 1ps

module simple_language_tokenizer_core_test
    import slt_pkg::*;
();

    localparam int NAME_LEN     = 32;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_BYTES = 25;
    localparam int SETTLE       = 40;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        char_valid;
    logic        char_ready;
    logic [7:0]  char_code;
    logic        token_valid;
    logic        token_ready;
    logic [3:0]  token_kind;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic [30:0] number_value;
    logic [5:0]  name_length;
    logic [7:0]  name_char;
    logic        name_truncated;
    logic        last_result;

    int   failures;
    int   pending;
    int   tokens_checked;
    int   bytes_sent;
    int   stall_cycles;
    int   random_start;
    logic calm;
    logic long_hold;

    simple_language_tokenizer_core #(
        .MAX_NAME_LEN(NAME_LEN)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_ready    (char_ready),
        .char_code     (char_code),
        .token_valid   (token_valid),
        .token_ready   (token_ready),
        .token_kind    (token_kind),
        .token_line    (token_line),
        .token_column  (token_column),
        .number_value  (number_value),
        .name_length   (name_length),
        .name_char     (name_char),
        .name_truncated(name_truncated),
        .last_result   (last_result)
    );

    token_checker #(
        .NAME_LEN(NAME_LEN)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_ready    (char_ready),
        .char_code     (char_code),
        .token_valid   (token_valid),
        .token_ready   (token_ready),
        .token_kind    (token_kind),
        .token_line    (token_line),
        .token_column  (token_column),
        .number_value  (number_value),
        .name_length   (name_length),
        .name_char     (name_char),
        .name_truncated(name_truncated),
        .last_result   (last_result),
        .failures      (failures),
        .pending       (pending),
        .tokens_checked(tokens_checked)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_valid && char_ready) || (token_valid && token_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT)
            begin
                $display("simple_language_tokenizer_core_test failed");
                $finish;
            end
        end
    end

    initial
    begin
        token_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                token_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
                token_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                token_ready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge clk);
            end
            else
                token_ready <= 1'b1;
        end
    end

    task automatic send_char(input logic [7:0] b);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        char_valid <= 1'b1;
        char_code  <= b;
        do @(posedge clk); while (!char_ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    function automatic logic [7:0] random_word_char();
        int r;
        r = $urandom_range(0, 63);
        if (r < 26)
            return 8'(65 + r);
        else if (r < 52)
            return 8'(97 + r - 26);
        else if (r < 62)
            return 8'(CH_ZERO + r - 52);
        return CH_UNDER;
    endfunction

    task automatic send_word(input int len);
        send_char(8'(($urandom_range(0, 1) ? 65 : 97) + $urandom_range(0, 25)));
        repeat (len - 1) send_char(random_word_char());
    endtask

    task automatic send_random_token();
        string punct;
        int    pick;
        int    r;
        punct = "!#$%&(),.:;<>?@[]^_{|}~";
        pick = $urandom_range(0, 19);
        if (pick < 6)
        begin
            if ($urandom_range(0, 11) == 0)
                send_word($urandom_range(NAME_LEN - 1, NAME_LEN + 4));
            else
                send_word($urandom_range(1, 6));
        end
        else if (pick < 8)
        begin
            case ($urandom_range(0, 9))
                0: send_text("let");
                1: send_text("print");
                2: send_text("le");
                3: send_text("lets");
                4: send_text("prin");
                5: send_text("printx");
                6: send_text("Let");
                7: send_text("PRINT");
                8: send_text("let_");
                default: send_text("print9");
            endcase
        end
        else if (pick < 11)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: send_text("2147483647");
                    1: send_text("2147483648");
                    2: send_text("4294967296");
                    default: send_text("99999999999");
                endcase
            end
            else
                repeat ($urandom_range(1, 4)) send_char(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        else if (pick < 14)
        begin
            case ($urandom_range(0, 4))
                0: send_char(CH_PLUS);
                1: send_char(CH_MINUS);
                2: send_char(CH_STAR);
                3: send_char(CH_SLASH);
                default: send_char(CH_ASSIGN);
            endcase
        end
        else if (pick == 14)
        begin
            r = $urandom_range(0, 3);
            if (r == 0)
                send_char(8'($urandom_range(128, 255)));
            else if (r == 1)
            begin
                r = $urandom_range(1, 31);
                send_char((r == 10) ? 8'd13 : 8'(r));
            end
            else if (r == 2)
                send_char(punct[$urandom_range(0, punct.len() - 1)]);
            else
                send_char(8'd127);
        end
        else if (pick == 15)
            send_char(CH_NL);
        else if (pick == 16)
            send_char(CH_END);
        if ($urandom_range(0, 1) == 0)
            send_char(CH_SPACE);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        char_valid   = 1'b0;
        char_code    = '0;
        calm         = 1'b0;
        long_hold    = 1'b0;
        bytes_sent   = 0;
        stall_cycles = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_text("let x_9=99+-*/");
        send_char(8'h09);
        send_char(8'hFF);
        send_char(CH_NL);
        send_text("print");
        send_char(CH_END);

        // stall the receiver while operator tokens pile up behind it, then send a long identifier
        @(posedge clk);
        long_hold = 1'b1;
        @(negedge clk);
        send_text("+-*/=+-*/=");
        send_text("print");
        repeat (NAME_LEN) send_char(random_word_char());
        send_char(CH_ASSIGN);

        random_start = bytes_sent;
        while (bytes_sent < random_start + RANDOM_BYTES)
            send_random_token();

        calm = 1'b1;
        repeat (6) send_random_token();
        send_char(CH_END);
        char_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("Ran %0d text bytes through the tokenizer and checked %0d tokens.",
                 bytes_sent, tokens_checked);
        $display("Covered keywords, truncated names, saturated numbers, odd bytes and stalls.");
        if (failures == 0 && pending == 0)
            $display("simple_language_tokenizer_core_test passed");
        else
            $display("simple_language_tokenizer_core_test failed");
        $finish;
    end

endmodule
